// ===== rtl/core/history_ring_with_cursor_assert.svh =====
// Assertion macros for the history ring.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef HISTORY_RING_WITH_CURSOR_ASSERT_SVH
`define HISTORY_RING_WITH_CURSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hrc_pkg.sv =====
// Shared constants for the history ring: op codes, field widths, defaults.
// No dependencies.
package hrc_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_ENTRY_BITS = 64;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_PREV  = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;
    localparam logic [OP_W-1:0] OP_HOME  = 2'd3;

endpackage

// ===== rtl/core/hrc_store.sv =====
// Entry storage for the history ring: one write port, one registered read port.
// Depends on hrc_pkg for default sizes.
module hrc_store
    import hrc_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int ENTRY_BITS = DEF_ENTRY_BITS,
    parameter int SW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [SW-1:0]         i_wr_slot,
    input  logic [ENTRY_BITS-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [SW-1:0]         i_rd_slot,
    output logic [ENTRY_BITS-1:0] o_rd_data
);

    logic [ENTRY_BITS-1:0] r_mem [DEPTH];
    logic [ENTRY_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/history_ring_with_cursor.sv =====
// History ring with a browse cursor: control, pointers and result register.
// Depends on hrc_pkg, hrc_store and history_ring_with_cursor_assert.svh.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   i_op selects add (store i_entry_value unless it matches the newest entry),
//   previous, next, or cursor home. i_entry_value matters only for add.
//   Every request gives exactly one result: o_valid is high for one cycle with
//   o_entry_out, o_entry_present and o_stored_count. The receiver cannot stall;
//   the result is gone after that cycle.
//   Order: the request edge reads the entry store (newest slot for add, the
//   cursor target for previous/next); the write-back edge compares, writes back,
//   updates the pointers and registers the result, which o_valid then shows.
//   A new request is not taken until the previous one is written back: the
//   registered store read is followed by write-back. busy is high during write-back.
//   Because the write lands before any later read is issued, no forwarding is
//   needed.
//   Reset (i_rst_n low, synchronous) empties the ring and homes the cursor;
//   the store is not cleared; an unwritten slot may be read, its data unused.
module history_ring_with_cursor
    import hrc_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    i_op,
    input  logic [VALUE_W-1:0] i_entry_value,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_entry_out,
    output logic               o_entry_present,
    output logic [COUNT_W-1:0] o_stored_count
);

`include "history_ring_with_cursor_assert.svh"

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // slot arithmetic modulo DEPTH (DEPTH need not be a power of two)
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : SW'(s + 1'b1);
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
        return (s == '0) ? LAST_SLOT : SW'(s - 1'b1);
    endfunction

    logic                  r_state, n_state;
    logic [OP_W-1:0]       r_op;
    logic [ENTRY_BITS-1:0] r_value;

    // ring pointers
    logic [SW-1:0] r_oldest, n_oldest;
    logic [SW-1:0] r_next_free, n_next_free;
    logic [SW-1:0] r_newest, n_newest;
    logic [SW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_steps, n_steps;
    logic [CW-1:0] r_count, n_count;

    // result register
    logic                  r_valid;
    logic [ENTRY_BITS-1:0] r_out, n_out;
    logic                  r_present, n_present;

    logic                  accept;
    logic                  exec;
    logic [SW-1:0]         rd_slot;
    logic [ENTRY_BITS-1:0] rd_data;
    logic                  wr_en;

    assign accept = start && (r_state == ST_IDLE);
    assign exec   = (r_state == ST_EXEC);
    assign busy   = exec;

    // Read target; pointers do not move between request and write-back,
    // so the same decision is valid in both cycles.
    always_comb begin
        rd_slot = r_cursor;
        case (i_op)
            OP_ADD:  rd_slot = r_newest;
            OP_PREV: rd_slot = (r_steps < r_count) ? slot_dec(r_cursor) : r_oldest;
            OP_NEXT: rd_slot = slot_inc(r_cursor);
            default: rd_slot = r_cursor;
        endcase
    end

    hrc_store #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS),
        .SW         (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_slot (r_next_free),
        .i_wr_data (r_value),
        .i_rd_en   (accept),
        .i_rd_slot (rd_slot),
        .o_rd_data (rd_data)
    );

    // write-back step
    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_next_free = r_next_free;
        n_newest    = r_newest;
        n_cursor    = r_cursor;
        n_steps     = r_steps;
        n_count     = r_count;
        n_out       = '0;
        n_present   = 1'b0;
        wr_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_op)
                    OP_ADD: begin
                        // duplicate of newest entry: just home the cursor
                        if ((r_count != '0) && (rd_data == r_value)) begin
                            n_cursor = r_next_free;
                        end else begin
                            wr_en       = 1'b1;
                            n_newest    = r_next_free;
                            n_next_free = slot_inc(r_next_free);
                            n_cursor    = slot_inc(r_next_free);
                            if (r_count < FULL_CNT) begin
                                n_count = CW'(r_count + 1'b1);
                            end else begin
                                n_oldest = slot_inc(r_oldest);
                            end
                        end
                        n_steps = '0;
                    end
                    OP_PREV: begin
                        if (r_steps < r_count) begin
                            n_steps   = CW'(r_steps + 1'b1);
                            n_cursor  = slot_dec(r_cursor);
                            n_out     = rd_data;
                            n_present = 1'b1;
                        end else if (r_count != '0) begin
                            // pinned at the oldest entry
                            n_cursor  = r_oldest;
                            n_out     = rd_data;
                            n_present = 1'b1;
                        end
                    end
                    OP_NEXT: begin
                        if (r_steps > CW'(1)) begin
                            n_steps   = CW'(r_steps - 1'b1);
                            n_cursor  = slot_inc(r_cursor);
                            n_out     = rd_data;
                            n_present = 1'b1;
                        end else begin
                            n_cursor = r_next_free;
                            n_steps  = '0;
                        end
                    end
                    default: begin
                        n_cursor = r_next_free;
                        n_steps  = '0;
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_next_free <= '0;
            r_newest    <= '0;
            r_cursor    <= '0;
            r_steps     <= '0;
            r_count     <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_next_free <= n_next_free;
            r_newest    <= n_newest;
            r_cursor    <= n_cursor;
            r_steps     <= n_steps;
            r_count     <= n_count;
            r_valid     <= exec;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_value <= i_entry_value[ENTRY_BITS-1:0];
        end
        if (exec) begin
            r_out     <= n_out;
            r_present <= n_present;
        end
    end

    assign o_valid         = r_valid;
    assign o_entry_out     = VALUE_W'(r_out);
    assign o_entry_present = r_present;
    assign o_stored_count  = COUNT_W'(r_count);

    `HRC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy && !o_valid,
        "request taken but write-back not started")
    `HRC_ASSERT_NXT(a_exec_result, i_clk, i_rst_n, exec, o_valid && !busy,
        "write-back did not produce exactly one result")
    `HRC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count <= FULL_CNT) && (r_steps <= r_count), "ring count or step count out of range")
    `HRC_ASSERT_IMP(a_present_op, i_clk, i_rst_n, o_valid && o_entry_present,
        (r_op == OP_PREV || r_op == OP_NEXT) && (r_count != '0),
        "entry returned for a request that cannot return one")

endmodule

// ===== dv/history_ring_with_cursor_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for history_ring_with_cursor: directed table, then random bursts.
// Depends on hrc_pkg and the history_ring_with_cursor RTL; needs no files or arguments.
module history_ring_with_cursor_tb;
    import hrc_pkg::*;

    localparam int DEPTH        = DEF_DEPTH;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL   = 200;      // last requests go out back to back
    localparam int DRAIN_CYCLES = 10;       // idle wait after the last result before finishing
    localparam int CYCLE_LIMIT  = 200000;   // ~1650 requests with idle gaps, write-back and result delay, x4 margin
    localparam int ROW_COUNT    = 16;

    // One request as queued for the driver; fixed rows carry a hand-written answer.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic               fixed;
        logic [VALUE_W-1:0] exp_entry;
        logic               exp_present;
        logic [COUNT_W-1:0] exp_count;
    } t_history_req;

    // Directed table row: same as a request plus a repeat count (adds step the value).
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        logic               fixed;
        logic [VALUE_W-1:0] exp_entry;
        logic               exp_present;
        logic [COUNT_W-1:0] exp_count;
    } t_history_row;

    typedef struct packed {
        logic [VALUE_W-1:0] entry;
        logic               present;
        logic [COUNT_W-1:0] count;
    } t_history_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_op = OP_HOME;
    logic [VALUE_W-1:0] i_entry_value = '0;
    logic               o_valid;
    logic [VALUE_W-1:0] o_entry_out;
    logic               o_entry_present;
    logic [COUNT_W-1:0] o_stored_count;

    history_ring_with_cursor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_entry_value  (i_entry_value),
        .o_valid        (o_valid),
        .o_entry_out    (o_entry_out),
        .o_entry_present(o_entry_present),
        .o_stored_count (o_stored_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_history_req    request_q[$];
    t_history_result pending_results[$];
    t_history_row    directed_rows[ROW_COUNT];

    int cycle_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int error_count   = 0;
    int gap_left      = 0;

    // Shadow copy of the ring: store, slot pointers, cursor and counters.
    logic [VALUE_W-1:0] history_mem[DEPTH];
    int oldest_slot    = 0;
    int next_free_slot = 0;
    int newest_slot    = 0;
    int cursor_slot    = 0;
    int steps_back     = 0;
    int entry_count    = 0;

    // Corner-case tallies for the summary.
    int dup_adds       = 0;
    int full_adds      = 0;
    int oldest_repeats = 0;

    // Advance the shadow ring by one request and return the answer it owes.
    task automatic predict_history(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                   output t_history_result res);
        res = '0;
        case (op)
            OP_ADD: begin
                // duplicate check only counts once something is stored
                if (entry_count > 0 && history_mem[newest_slot] == value) begin
                    dup_adds++;
                end else begin
                    history_mem[next_free_slot] = value;
                    newest_slot    = next_free_slot;
                    next_free_slot = (next_free_slot + 1) % DEPTH;
                    if (entry_count < DEPTH) begin
                        entry_count++;
                    end else begin
                        // full ring: oldest entry was just overwritten
                        oldest_slot = (oldest_slot + 1) % DEPTH;
                        full_adds++;
                    end
                end
                cursor_slot = next_free_slot;
                steps_back  = 0;
            end
            OP_PREV: begin
                if (steps_back < entry_count) begin
                    steps_back++;
                    cursor_slot = (cursor_slot + DEPTH - 1) % DEPTH;
                    res.entry   = history_mem[cursor_slot];
                    res.present = 1'b1;
                end else if (entry_count > 0) begin
                    // parked at the oldest end, keep answering with it
                    cursor_slot = oldest_slot;
                    res.entry   = history_mem[cursor_slot];
                    res.present = 1'b1;
                    oldest_repeats++;
                end
            end
            OP_NEXT: begin
                if (steps_back > 1) begin
                    steps_back--;
                    cursor_slot = (cursor_slot + 1) % DEPTH;
                    res.entry   = history_mem[cursor_slot];
                    res.present = 1'b1;
                end else begin
                    // back at the newest end: empty answer, step count clears
                    cursor_slot = next_free_slot;
                    steps_back  = 0;
                end
            end
            default: begin
                cursor_slot = next_free_slot;
                steps_back  = 0;
            end
        endcase
        res.count = entry_count[COUNT_W-1:0];
    endtask

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        t_history_req req;
        req       = '0;
        req.op    = op;
        req.value = value;
        request_q.push_back(req);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Build the request list: directed table first, then random bursts.
    initial begin
        t_history_req       req;
        logic [VALUE_W-1:0] last_added;
        logic [VALUE_W-1:0] value;
        int burst;
        int mode;
        int random_count;

        // op, value, reps, fixed, expected entry, expected present, expected count
        directed_rows = '{
            '{OP_PREV, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd0},  // empty ring
            '{OP_NEXT, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd0},
            '{OP_HOME, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd0},
            '{OP_ADD,  64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd1},  // zero into empty
            '{OP_ADD,  64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd1},  // duplicate
            '{OP_ADD,  {64{1'b1}},              5'd1,  1'b1, 64'd0, 1'b0, 5'd2},
            '{OP_PREV, 64'd0,                   5'd1,  1'b1, {64{1'b1}}, 1'b1, 5'd2},
            '{OP_PREV, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b1, 5'd2},
            '{OP_PREV, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b1, 5'd2},  // oldest end
            '{OP_NEXT, 64'd0,                   5'd1,  1'b1, {64{1'b1}}, 1'b1, 5'd2},
            '{OP_NEXT, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd2},  // newest end
            '{OP_ADD,  {64{1'b1}},              5'd1,  1'b1, 64'd0, 1'b0, 5'd2},  // duplicate
            '{OP_ADD,  64'h8000_0000_0000_0001, 5'd15, 1'b0, 64'd0, 1'b0, 5'd0},  // fill, wrap
            '{OP_PREV, 64'd0,                   5'd2,  1'b0, 64'd0, 1'b0, 5'd0},
            '{OP_HOME, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd16},
            '{OP_NEXT, 64'd0,                   5'd1,  1'b1, 64'd0, 1'b0, 5'd16}
        };

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                req.op          = directed_rows[r].op;
                req.value       = directed_rows[r].value + 64'(k);
                req.fixed       = directed_rows[r].fixed;
                req.exp_entry   = directed_rows[r].exp_entry;
                req.exp_present = directed_rows[r].exp_present;
                req.exp_count   = directed_rows[r].exp_count;
                request_q.push_back(req);
            end
        end
        last_added = 64'h8000_0000_0000_0001 + 64'd14;

        // Bursts of like operations so the cursor walks deep into the ring and the
        // ring wraps; adds often repeat the newest value to hit the duplicate path.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            mode  = $urandom_range(0, 9);
            burst = (mode == 9) ? 1 : $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) begin
                if (mode <= 3) begin
                    case ($urandom_range(0, 7))
                        0, 1:    value = last_added;
                        2: begin
                            case ($urandom_range(0, 3))
                                0:       value = '0;
                                1:       value = '1;
                                2:       value = 64'd1;
                                default: value = {1'b1, 63'd0};
                            endcase
                        end
                        default: value = {$urandom, $urandom};
                    endcase
                    last_added = value;
                    queue_request(OP_ADD, value);
                end else if (mode <= 6) begin
                    queue_request(OP_PREV, {$urandom, $urandom});
                end else if (mode <= 8) begin
                    queue_request(OP_NEXT, {$urandom, $urandom});
                end else begin
                    queue_request(OP_HOME, {$urandom, $urandom});
                end
                random_count++;
            end
        end
    end

    // Reset, result checking and request driving share one clocked process so the
    // order of push and pop within an edge is fixed.
    always @(posedge i_clk) begin
        t_history_result predicted;
        t_history_result expected;
        t_history_req    req;
        bit              take;

        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            if (cycle_count == RESET_CYCLES - 1) begin
                i_rst_n <= 1'b1;
            end
        end else begin
            // results: one strobe cycle each, compared with the oldest expectation
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h/%b/%0d", $time,
                             o_entry_out, o_entry_present, o_stored_count);
                    error_count++;
                end else begin
                    expected = pending_results.pop_front();
                    check_field("entry_out", expected.entry, o_entry_out);
                    check_field("entry_present", 64'(expected.present), 64'(o_entry_present));
                    check_field("stored_count", 64'(expected.count), 64'(o_stored_count));
                    checked_count++;
                end
            end

            // request taken at this edge
            take = !start || !busy;
            if (start && !busy) begin
                predict_history(i_op, i_entry_value, predicted);
                req = request_q[sent_count];
                if (req.fixed) begin
                    expected.entry   = req.exp_entry;
                    expected.present = req.exp_present;
                    expected.count   = req.exp_count;
                    pending_results.push_back(expected);
                end else begin
                    pending_results.push_back(predicted);
                end
                sent_count++;
            end

            // next request, with idle bursts except in quiet windows and the tail
            if (take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (sent_count < request_q.size()) begin
                    if (sent_count + QUIET_TAIL < request_q.size() &&
                        (sent_count / 150) % 4 != 3 && $urandom_range(0, 99) < 20) begin
                        gap_left = $urandom_range(0, 18);
                        start <= 1'b0;
                    end else begin
                        start         <= 1'b1;
                        i_op          <= request_q[sent_count].op;
                        i_entry_value <= request_q[sent_count].value;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Normal end: every request sent, every result seen, then a short drain.
    initial begin
        do @(posedge i_clk);
        while (!(i_rst_n && sent_count == request_q.size() && pending_results.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests, checked %0d results in %0d cycles.", sent_count,
                 checked_count, cycle_count);
        $display("Covered %0d duplicate adds, %0d adds to a full ring, %0d repeats at oldest.",
                 dup_adds, full_adds, oldest_repeats);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog on the cycle counter.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== history_ring_with_cursor.f =====
+incdir+rtl/core
rtl/core/hrc_pkg.sv
rtl/core/hrc_store.sv
rtl/core/history_ring_with_cursor.sv
dv/history_ring_with_cursor_tb.sv
